>>> design/rtp_pkg.sv
// ----------------------------------------------------------------------------
// rtp_pkg - shared definitions for the route TLV parser
// Section codes, format flag bits, field codes and the fixed-field table.
// ----------------------------------------------------------------------------
package rtp_pkg;

  localparam logic [3:0] PH_NHOP  = 4'd0;
  localparam logic [3:0] PH_NAMED = 4'd1;
  localparam logic [3:0] PH_WOFF  = 4'd2;
  localparam logic [3:0] PH_WBODY = 4'd3;
  localparam logic [3:0] PH_WATTR = 4'd4;
  localparam logic [3:0] PH_EXT   = 4'd5;
  localparam logic [3:0] PH_CMET  = 4'd6;
  localparam logic [3:0] PH_PLEN  = 4'd7;
  localparam logic [3:0] PH_PFX   = 4'd8;

  localparam int FL_WIDE  = 0;
  localparam int FL_EXT   = 1;
  localparam int FL_NAMED = 2;
  localparam int FL_V6    = 3;

  localparam logic [4:0] CODE_HOP_LO  = 5'd0;
  localparam logic [4:0] CODE_HOP_HI  = 5'd1;
  localparam logic [4:0] CODE_DELAY   = 5'd10;
  localparam logic [4:0] CODE_BW      = 5'd11;
  localparam logic [4:0] CODE_ATTR    = 5'd13;
  localparam logic [4:0] CODE_PLEN    = 5'd20;
  localparam logic [4:0] CODE_PFX_LO  = 5'd21;
  localparam logic [4:0] CODE_PFX_HI  = 5'd22;
  localparam logic [4:0] CODE_DONE    = 5'd23;

  localparam int NREC  = 4;
  localparam int NSLOT = 25;

  localparam logic [31:0] BW_NUM    = 32'd2560000000;
  localparam logic [23:0] DELAY_MUL = 24'd10000000;

  typedef struct packed {
    logic [3:0] phase;
    logic [4:0] last;
    logic [2:0] bytes;
    logic [4:0] code;
  } slot_t;

  typedef enum logic [1:0] {CV_NONE, CV_DELAY, CV_BW} conv_t;

  typedef struct packed {
    logic [4:0]  code;
    logic [63:0] value;
    logic        err;
    logic        last;
  } rec_t;

  localparam slot_t SLOTS [NSLOT] = '{
    '{PH_NAMED, 5'd1, 3'd2, 5'd2}, '{PH_NAMED, 5'd3, 3'd2, 5'd3},
    '{PH_NAMED, 5'd7, 3'd4, 5'd4},
    '{PH_WBODY, 5'd0, 3'd1, 5'd5}, '{PH_WBODY, 5'd1, 3'd1, 5'd6},
    '{PH_WBODY, 5'd2, 3'd1, 5'd7}, '{PH_WBODY, 5'd5, 3'd3, 5'd8},
    '{PH_WBODY, 5'd6, 3'd1, 5'd9}, '{PH_WBODY, 5'd12, 3'd6, 5'd10},
    '{PH_WBODY, 5'd18, 3'd6, 5'd11}, '{PH_WBODY, 5'd21, 3'd1, 5'd12},
    '{PH_EXT, 5'd3, 3'd4, 5'd14}, '{PH_EXT, 5'd7, 3'd4, 5'd15},
    '{PH_EXT, 5'd11, 3'd4, 5'd16}, '{PH_EXT, 5'd15, 3'd4, 5'd17},
    '{PH_EXT, 5'd18, 3'd1, 5'd18}, '{PH_EXT, 5'd19, 3'd1, 5'd19},
    '{PH_CMET, 5'd3, 3'd4, 5'd10}, '{PH_CMET, 5'd7, 3'd4, 5'd11},
    '{PH_CMET, 5'd10, 3'd3, 5'd8}, '{PH_CMET, 5'd11, 3'd1, 5'd9},
    '{PH_CMET, 5'd12, 3'd1, 5'd6}, '{PH_CMET, 5'd13, 3'd1, 5'd7},
    '{PH_CMET, 5'd14, 3'd1, 5'd16}, '{PH_CMET, 5'd15, 3'd1, 5'd12}
  };

  function automatic rec_t mk_rec(logic [4:0] code, logic [63:0] value,
                                  logic err, logic last);
    rec_t r;
    r.code  = code;
    r.value = value;
    r.err   = err;
    r.last  = last;
    return r;
  endfunction

endpackage

>>> design/route_tlv_parser.sv
// ----------------------------------------------------------------------------
// route_tlv_parser - byte-serial route TLV decoder
// Decodes one route TLV value into code/value records.
// ----------------------------------------------------------------------------
// Input channel: one byte per transaction (in_valid/in_stall), with first and
// last marks; format flags are sampled with the first byte.
// Output channel: records (out_valid/out_stall) carrying field_code,
// field_value, parse_error and last_record.
// Each byte yields zero to four records. A byte with no record leaves the
// input free. Otherwise the records are presented one per cycle, while
// out_stall is low, from a four-entry record register, and the input stays
// stalled until the last one is taken.
// A classic delay passes a multiply state and a saturate state; a classic
// bandwidth runs the bit-serial divider.
// Reset clears the parser state to a classic, internal, IPv4 route awaiting
// its next hop. A stalled receiver holds the current record unchanged.
// ----------------------------------------------------------------------------
module route_tlv_parser import rtp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic        is_wide,
  input  logic        is_external,
  input  logic        is_named,
  input  logic        is_ipv6,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  field_code,
  output logic [63:0] field_value,
  output logic        parse_error,
  output logic        last_record
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SAT, S_DIV, S_EMIT} st_t;

  st_t state;
  logic [3:0]   phase;
  logic [5:0]   bis;
  logic [127:0] acc;
  logic [3:0]   flags;
  logic [8:0]   abl;
  logic         fin;
  logic         fail;
  rec_t         recs [NREC];
  logic [2:0]   cnt;
  logic [1:0]   idx;
  conv_t        cv;
  logic [1:0]   cv_idx;
  logic [55:0]  prod;
  logic [32:0]  rem;
  logic [31:0]  quo;
  logic [31:0]  dsr;
  logic [4:0]   dcnt;

  logic [3:0]   phase_next;
  logic [5:0]   bis_next;
  logic [127:0] acc_next;
  logic [3:0]   flags_next;
  logic [8:0]   abl_next;
  logic         fin_next;
  logic         fail_next;
  rec_t         recs_next [NREC];
  logic [2:0]   cnt_next;
  conv_t        cv_next;
  logic [1:0]   cv_idx_next;

  logic [4:0]   ab;
  logic [7:0]   ab8;
  logic [4:0]   seclen;
  logic [9:0]   psz;
  logic         do_fin;
  logic [63:0]  v;
  logic [4:0]   psize;
  logic [7:0]   shamt;
  logic [7:0]   k;
  logic [127:0] mask;
  logic [32:0]  r2;
  logic [47:0]  dly;

  always_comb begin
    phase_next  = phase;
    bis_next    = bis;
    acc_next    = acc;
    flags_next  = flags;
    abl_next    = abl;
    fin_next    = fin;
    fail_next   = fail;
    cnt_next    = 3'd0;
    cv_next     = CV_NONE;
    cv_idx_next = 2'd0;
    do_fin      = 1'b0;
    v           = '0;
    psize       = '0;
    shamt       = '0;
    k           = '0;
    mask        = '0;
    for (int j = 0; j < NREC; j++) recs_next[j] = recs[j];

    if (first_byte) begin
      flags_next = {is_ipv6, is_named, is_external, is_wide};
      abl_next   = '0;
      fin_next   = 1'b0;
      fail_next  = 1'b0;
      phase_next = is_wide ? (is_named ? PH_NAMED : PH_WOFF) : PH_NHOP;
      bis_next   = '0;
      acc_next   = '0;
    end
    ab  = flags_next[FL_V6] ? 5'd16 : 5'd4;
    ab8 = flags_next[FL_V6] ? 8'd128 : 8'd32;
    case (phase_next)
      PH_NAMED: seclen = 5'd8;
      PH_WBODY: seclen = 5'd23;
      PH_EXT:   seclen = 5'd20;
      default:  seclen = 5'd16;
    endcase
    psz = {1'b0, abl_next} + 10'd7;

    if (!(fin_next || fail_next)) begin
      case (phase_next) inside
        PH_NHOP: begin
          acc_next = {acc_next[119:0], data_byte};
          bis_next = bis_next + 6'd1;
          if (bis_next >= {1'b0, ab}) begin
            recs_next[0] = mk_rec(CODE_HOP_LO, acc_next[63:0], 1'b0, 1'b0);
            recs_next[1] = mk_rec(CODE_HOP_HI, acc_next[127:64], 1'b0, 1'b0);
            cnt_next = 3'd2;
            if (flags_next[FL_EXT]) phase_next = PH_EXT;
            else phase_next = flags_next[FL_WIDE] ? PH_PLEN : PH_CMET;
            bis_next = '0;
            acc_next = '0;
          end
        end
        PH_NAMED, PH_WBODY, PH_EXT, PH_CMET: begin
          acc_next = {acc_next[119:0], data_byte};
          for (int i = 0; i < NSLOT; i++) begin
            if (SLOTS[i].phase == phase_next && {1'b0, SLOTS[i].last} == bis_next) begin
              v = acc_next[63:0] & ((64'd1 << {SLOTS[i].bytes, 3'b000}) - 64'd1);
              if (phase_next == PH_CMET && SLOTS[i].code == CODE_DELAY && v != '0)
                cv_next = CV_DELAY;
              else if (phase_next == PH_CMET && SLOTS[i].code == CODE_BW && v != '0)
                cv_next = CV_BW;
              else if (phase_next == PH_WBODY && SLOTS[i].code == CODE_DELAY &&
                       v[63:32] != '0)
                v = '1;
              recs_next[0] = mk_rec(SLOTS[i].code, v, 1'b0, 1'b0);
              cnt_next = 3'd1;
              acc_next = '0;
            end
          end
          bis_next = bis_next + 6'd1;
          if (bis_next >= {1'b0, seclen}) begin
            case (phase_next)
              PH_NAMED: phase_next = PH_WOFF;
              PH_WBODY: phase_next = (abl_next != '0) ? PH_WATTR : PH_NHOP;
              PH_EXT:   phase_next = flags_next[FL_WIDE] ? PH_PLEN : PH_CMET;
              default:  phase_next = PH_PLEN;
            endcase
            bis_next = '0;
            acc_next = '0;
          end
        end
        PH_WOFF: begin
          abl_next   = {data_byte, 1'b0};
          phase_next = PH_WBODY;
          bis_next   = '0;
          acc_next   = '0;
        end
        PH_WATTR: begin
          recs_next[0] = mk_rec(CODE_ATTR, {56'd0, data_byte}, 1'b0, 1'b0);
          cnt_next = 3'd1;
          if (abl_next != '0) abl_next = abl_next - 9'd1;
          if (abl_next == '0) begin
            phase_next = PH_NHOP;
            bis_next   = '0;
            acc_next   = '0;
          end
        end
        PH_PLEN: begin
          if (data_byte > ab8) begin
            recs_next[0] = mk_rec(CODE_DONE, '0, 1'b1, 1'b1);
            cnt_next  = 3'd1;
            fail_next = 1'b1;
          end else begin
            recs_next[0] = mk_rec(CODE_PLEN, {56'd0, data_byte}, 1'b0, 1'b0);
            cnt_next   = 3'd1;
            abl_next   = {1'b0, data_byte};
            phase_next = PH_PFX;
            bis_next   = '0;
            acc_next   = '0;
            if (data_byte == '0) do_fin = 1'b1;
          end
        end
        PH_PFX: begin
          acc_next = {acc_next[119:0], data_byte};
          bis_next = bis_next + 6'd1;
          if ({1'b0, bis_next} >= psz[9:3]) do_fin = 1'b1;
        end
        default: ;
      endcase
    end

    if (do_fin) begin
      psz   = {1'b0, abl_next} + 10'd7;
      psize = psz[7:3];
      shamt = {ab - psize, 3'b000};
      acc_next = acc_next << shamt;
      k = ab8 - abl_next[7:0];
      mask = (k >= 8'd128) ? '0 : ('1 << k);
      acc_next = acc_next & mask;
      recs_next[cnt_next[1:0]] = mk_rec(CODE_PFX_LO, acc_next[63:0], 1'b0, 1'b0);
      recs_next[cnt_next[1:0] + 2'd1] = mk_rec(CODE_PFX_HI, acc_next[127:64], 1'b0, 1'b0);
      recs_next[cnt_next[1:0] + 2'd2] = mk_rec(CODE_DONE, '0, 1'b0, 1'b1);
      cnt_next = cnt_next + 3'd3;
      fin_next = 1'b1;
    end

    if (last_byte && !fin_next && !fail_next) begin
      recs_next[cnt_next[1:0]] = mk_rec(CODE_DONE, '0, 1'b1, 1'b1);
      cnt_next  = cnt_next + 3'd1;
      fail_next = 1'b1;
    end
  end

  assign r2  = {rem[31:0], BW_NUM[dcnt]};
  assign dly = prod[55:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_NHOP;
      bis   <= '0;
      acc   <= '0;
      flags <= '0;
      abl   <= '0;
      fin   <= 1'b0;
      fail  <= 1'b0;
      cnt   <= '0;
      idx   <= '0;
      cv    <= CV_NONE;
      cv_idx <= '0;
      dcnt  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            phase <= phase_next;
            bis   <= bis_next;
            acc   <= acc_next;
            flags <= flags_next;
            abl   <= abl_next;
            fin   <= fin_next;
            fail  <= fail_next;
            for (int j = 0; j < NREC; j++) recs[j] <= recs_next[j];
            cnt    <= cnt_next;
            idx    <= '0;
            cv     <= cv_next;
            cv_idx <= cv_idx_next;
            rem    <= '0;
            quo    <= '0;
            dsr    <= recs_next[0].value[31:0];
            dcnt   <= 5'd31;
            if (cv_next == CV_DELAY) state <= S_MUL;
            else if (cv_next == CV_BW) state <= S_DIV;
            else if (cnt_next != '0) state <= S_EMIT;
          end
        end
        S_MUL: begin
          prod  <= {24'd0, recs[cv_idx].value[31:0]} * {32'd0, DELAY_MUL};
          state <= S_SAT;
        end
        S_SAT: begin
          recs[cv_idx].value <= (dly > 48'hFFFFFF) ? '1 : {16'd0, dly};
          state <= S_EMIT;
        end
        S_DIV: begin
          if (r2 >= {1'b0, dsr}) begin
            rem <= r2 - {1'b0, dsr};
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= r2;
            quo <= {quo[30:0], 1'b0};
          end
          dcnt <= dcnt - 5'd1;
          if (dcnt == '0) begin
            recs[cv_idx].value <= {32'd0, quo[30:0], r2 >= {1'b0, dsr}};
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            if ({1'b0, idx} == cnt - 3'd1) begin
              idx   <= '0;
              state <= S_IDLE;
            end else begin
              idx <= idx + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall    = (state != S_IDLE);
  assign out_valid   = (state == S_EMIT);
  assign field_code  = recs[idx].code;
  assign field_value = recs[idx].value;
  assign parse_error = recs[idx].err;
  assign last_record = recs[idx].last;

endmodule

>>> design/rtp_checker.sv
// ----------------------------------------------------------------------------
// rtp_checker - port-level checks for the route TLV parser
// Watches both channels and the record framing.
// ----------------------------------------------------------------------------
module rtp_checker import rtp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  field_code,
  input logic [63:0] field_value,
  input logic        parse_error,
  input logic        last_record
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(field_code) && $stable(field_value))
    else $error("stalled record changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while records pending");

  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_error |-> last_record && field_code == CODE_DONE && field_value == '0)
    else $error("malformed error record");

  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_record |=> !out_valid)
    else $error("record after end of route");

endmodule

bind route_tlv_parser rtp_checker u_rtp_checker (.*);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench - route TLV parser check
// Drives classic, wide, named, external and IPv6 routes a byte at a time with
// random gaps and output stalls, predicts every record in the bench itself
// and compares each record taken from the block with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import rtp_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       first;
    logic       last;
    logic [3:0] flags;
    int         gap;
    bit         drain;
  } tlv_byte_t;

  typedef struct {
    logic [4:0]  code;
    logic [63:0] value;
    logic        err;
    logic        last;
  } route_rec_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  data_byte = 0;
  logic        first_byte = 0;
  logic        last_byte = 0;
  logic        is_wide = 0;
  logic        is_external = 0;
  logic        is_named = 0;
  logic        is_ipv6 = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [4:0]  field_code;
  logic [63:0] field_value;
  logic        parse_error;
  logic        last_record;

  route_tlv_parser i_dut (.*);

  tlv_byte_t  byte_queue[$];
  route_rec_t expected_recs[$];
  int         fail_count = 0;
  int         bytes_sent = 0;
  int         recs_seen = 0;
  int         routes_built = 0;
  bit         stim_done = 0;

  // predictor state
  logic [3:0]   p_phase;
  int           p_idx;
  logic [127:0] p_acc;
  logic [3:0]   p_flags;
  int           p_left;
  bit           p_finished;
  bit           p_failed;

  initial forever #6 clk = ~clk;

  function automatic void add_rec(logic [4:0] c, logic [63:0] v, logic e, logic l);
    route_rec_t r;
    r.code = c; r.value = v; r.err = e; r.last = l;
    expected_recs.push_back(r);
  endfunction

  function automatic int addr_len();
    return p_flags[FL_V6] ? 16 : 4;
  endfunction

  function automatic void enter_section(logic [3:0] ph);
    p_phase = ph;
    p_idx = 0;
    p_acc = '0;
  endfunction

  function automatic void close_prefix();
    int ab;
    int sz;
    logic [127:0] m;
    ab = addr_len();
    sz = (p_left + 7) / 8;
    p_acc = p_acc << (8 * (ab - sz));
    m = (p_left == 0) ? '0 : ({128{1'b1}} << (8 * ab - p_left));
    p_acc = p_acc & m;
    add_rec(CODE_PFX_LO, p_acc[63:0], 1'b0, 1'b0);
    add_rec(CODE_PFX_HI, p_acc[127:64], 1'b0, 1'b0);
    add_rec(CODE_DONE, '0, 1'b0, 1'b1);
    p_finished = 1'b1;
  endfunction

  function automatic logic [63:0] scale_field(logic [3:0] ph, logic [4:0] c, logic [63:0] v);
    logic [63:0] r;
    r = v;
    if (ph == PH_CMET && c == CODE_DELAY && v != 0) begin
      r = (v * 64'd10000000) / 64'd256;
      if (r > 64'hFFFFFF) r = '1;
    end else if (ph == PH_CMET && c == CODE_BW && v != 0) begin
      r = 64'd2560000000 / v;
    end else if (ph == PH_WBODY && c == CODE_DELAY && v > 64'hFFFFFFFF) begin
      r = '1;
    end
    return r;
  endfunction

  function automatic void predict_byte(tlv_byte_t t);
    int slen;
    logic [63:0] v;
    logic [3:0] nxt;
    if (t.first) begin
      p_flags = t.flags;
      p_left = 0;
      p_finished = 1'b0;
      p_failed = 1'b0;
      if (p_flags[FL_WIDE]) enter_section(p_flags[FL_NAMED] ? PH_NAMED : PH_WOFF);
      else enter_section(PH_NHOP);
    end
    if (p_finished || p_failed) return;
    case (p_phase)
      PH_NHOP: begin
        p_acc = (p_acc << 8) | {120'd0, t.b};
        p_idx++;
        if (p_idx >= addr_len()) begin
          add_rec(CODE_HOP_LO, p_acc[63:0], 1'b0, 1'b0);
          add_rec(CODE_HOP_HI, p_acc[127:64], 1'b0, 1'b0);
          if (p_flags[FL_EXT]) nxt = PH_EXT;
          else nxt = p_flags[FL_WIDE] ? PH_PLEN : PH_CMET;
          enter_section(nxt);
        end
      end
      PH_NAMED, PH_WBODY, PH_EXT, PH_CMET: begin
        p_acc = (p_acc << 8) | {120'd0, t.b};
        for (int i = 0; i < NSLOT; i++) begin
          if (SLOTS[i].phase == p_phase && int'(SLOTS[i].last) == p_idx) begin
            v = p_acc[63:0] & ((64'd1 << (8 * int'(SLOTS[i].bytes))) - 64'd1);
            add_rec(SLOTS[i].code, scale_field(p_phase, SLOTS[i].code, v), 1'b0, 1'b0);
            p_acc = '0;
          end
        end
        p_idx++;
        slen = (p_phase == PH_NAMED) ? 8 : (p_phase == PH_WBODY) ? 23 :
               (p_phase == PH_EXT) ? 20 : 16;
        if (p_idx >= slen) begin
          if (p_phase == PH_NAMED) nxt = PH_WOFF;
          else if (p_phase == PH_WBODY) nxt = (p_left != 0) ? PH_WATTR : PH_NHOP;
          else if (p_phase == PH_EXT) nxt = p_flags[FL_WIDE] ? PH_PLEN : PH_CMET;
          else nxt = PH_PLEN;
          enter_section(nxt);
        end
      end
      PH_WOFF: begin
        p_left = int'(t.b) * 2;
        enter_section(PH_WBODY);
      end
      PH_WATTR: begin
        add_rec(CODE_ATTR, {56'd0, t.b}, 1'b0, 1'b0);
        if (p_left > 0) p_left--;
        if (p_left == 0) enter_section(PH_NHOP);
      end
      PH_PLEN: begin
        if (int'(t.b) > 8 * addr_len()) begin
          add_rec(CODE_DONE, '0, 1'b1, 1'b1);
          p_failed = 1'b1;
        end else begin
          add_rec(CODE_PLEN, {56'd0, t.b}, 1'b0, 1'b0);
          p_left = int'(t.b);
          enter_section(PH_PFX);
          if (t.b == 8'd0) close_prefix();
        end
      end
      PH_PFX: begin
        p_acc = (p_acc << 8) | {120'd0, t.b};
        p_idx++;
        if (p_idx >= (p_left + 7) / 8) close_prefix();
      end
      default: ;
    endcase
    if (t.last && !p_finished && !p_failed) begin
      add_rec(CODE_DONE, '0, 1'b1, 1'b1);
      p_failed = 1'b1;
    end
  endfunction

  function automatic void push_byte(logic [7:0] b, bit first, bit last, logic [3:0] fl);
    tlv_byte_t t;
    t.b = b; t.first = first; t.last = last; t.flags = fl;
    t.gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 6));
    t.drain = 1'b0;
    byte_queue.push_back(t);
  endfunction

  // Builds one route; mode 0 well formed, 1 truncated, 2 bad prefix length,
  // 3 trailing bytes, 4 unflagged noise.
  function automatic void build_route(logic [3:0] fl, int mode, int offs, int plen,
                                      bit extremes);
    logic [7:0] body[$];
    int ab;
    int n;
    int cut;
    routes_built++;
    ab = fl[FL_V6] ? 16 : 4;
    if (fl[FL_WIDE]) begin
      if (fl[FL_NAMED]) repeat (8) body.push_back(8'($urandom));
      body.push_back(8'(offs));
      repeat (23) body.push_back(extremes ? 8'hFF : 8'($urandom));
      repeat (offs * 2) body.push_back(8'($urandom));
      repeat (ab) body.push_back(8'($urandom));
      if (fl[FL_EXT]) repeat (20) body.push_back(8'($urandom));
    end else begin
      repeat (ab) body.push_back(8'($urandom));
      if (fl[FL_EXT]) repeat (20) body.push_back(8'($urandom));
      for (int i = 0; i < 16; i++) begin
        if (extremes) body.push_back(8'hFF);
        else if (i < 8 && $urandom_range(0, 3) == 0) body.push_back(8'h00);
        else if (i < 3 && $urandom_range(0, 1) == 0) body.push_back(8'h00);
        else body.push_back(8'($urandom));
      end
    end
    if (mode == 2) body.push_back(8'($urandom_range(8 * ab + 1, 255)));
    else body.push_back(8'(plen));
    if (mode != 2) repeat ((plen + 7) / 8) body.push_back(8'($urandom));
    if (mode == 3) repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
    n = body.size();
    cut = (mode == 1) ? int'($urandom_range(1, n - 1)) : n;
    for (int i = 0; i < cut; i++)
      push_byte(body[i], (mode != 4) && i == 0, i == cut - 1, fl);
  endfunction

  task automatic wait_idle();
    tlv_byte_t t;
    t = byte_queue[$];
    t.drain = 1'b1;
    byte_queue[$] = t;
  endtask

  initial begin
    logic [3:0] fl;
    int m;
    int ab;
    // directed
    build_route(4'b0000, 0, 0, 32, 1);
    build_route(4'b0000, 0, 0, 0, 0);
    build_route(4'b0011, 0, 0, 17, 1);
    build_route(4'b1111, 0, 1, 64, 0);
    wait_idle();
    build_route(4'b0001, 2, 0, 0, 0);
    build_route(4'b0101, 1, 0, 8, 0);
    build_route(4'b1001, 3, 0, 127, 0);
    build_route(4'b0000, 4, 0, 24, 0);
    wait_idle();
    // random
    while (byte_queue.size() < 310) begin
      fl = 4'($urandom);
      m = $urandom_range(0, 9);
      m = (m < 6) ? 0 : m - 5;
      ab = fl[FL_V6] ? 128 : 32;
      build_route(fl, m, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) :
                  $urandom_range(0, 2), $urandom_range(0, ab), 0);
      if ($urandom_range(0, 15) == 0) wait_idle();
    end
    stim_done = 1;
  end

  // driver
  int  gap_left = 0;
  bit  holding = 0;
  always @(posedge clk) begin
    tlv_byte_t t;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        bytes_sent++;
        predict_byte(byte_queue[0]);
        gap_left = byte_queue[0].gap;
        holding = byte_queue[0].drain;
        void'(byte_queue.pop_front());
      end
      if (in_valid && in_stall) begin
      end else if (holding && expected_recs.size() != 0) begin
        in_valid <= 0;
      end else if (gap_left > 0) begin
        gap_left--;
        holding = 0;
        in_valid <= 0;
      end else if (byte_queue.size() != 0) begin
        holding = 0;
        t = byte_queue[0];
        in_valid <= 1;
        data_byte <= t.b;
        first_byte <= t.first;
        last_byte <= t.last;
        is_wide <= t.flags[FL_WIDE];
        is_external <= t.flags[FL_EXT];
        is_named <= t.flags[FL_NAMED];
        is_ipv6 <= t.flags[FL_V6];
      end else begin
        in_valid <= 0;
      end
    end
  end

  // monitor
  int stall_left = 0;
  always @(posedge clk) begin
    route_rec_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        recs_seen++;
        if (expected_recs.size() == 0) begin
          $error("unexpected record code %0d value %h", field_code, field_value);
          fail_count++;
        end else begin
          e = expected_recs.pop_front();
          if (field_code !== e.code) begin
            $error("field_code expected %0d actual %0d", e.code, field_code);
            fail_count++;
          end
          if (field_value !== e.value) begin
            $error("field_value expected %h actual %h", e.value, field_value);
            fail_count++;
          end
          if (parse_error !== e.err) begin
            $error("parse_error expected %b actual %b", e.err, parse_error);
            fail_count++;
          end
          if (last_record !== e.last) begin
            $error("last_record expected %b actual %b", e.last, last_record);
            fail_count++;
          end
        end
        stall_left = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 6));
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  initial begin
    p_flags = 0; p_left = 0; p_finished = 0; p_failed = 0;
    enter_section(PH_NHOP);
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    wait (stim_done && byte_queue.size() == 0 && !in_valid && expected_recs.size() == 0);
    repeat (60) @(posedge clk);
    $display("Covered %0d routes, %0d bytes and %0d records across all layouts,",
             routes_built, bytes_sent, recs_seen);
    $display("with truncated, bad-length, trailing and unflagged routes.");
    if (fail_count == 0 && expected_recs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
design/rtp_pkg.sv
design/route_tlv_parser.sv
design/rtp_checker.sv
dv/testbench.sv
